FILE: rtl/assert_macros.svh
// Assertion macros shared by the ring modulator RTL.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising edge outside reset.
`define SRM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("srm assertion failed");

// A condition that must never be true outside reset.
`define SRM_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("srm forbidden condition seen");

`else

`define SRM_ASSERT(label, clk, rst_n, prop)
`define SRM_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/srm_pkg.sv
// Types, constants and the sine table builder for the stereo ring modulator.
// Used by every module of the block; depends on nothing.
package srm_pkg;

    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF     = 32;
    localparam int STEP_W             = 32;
    localparam int SAMPLE_W           = 16;
    localparam int QDEPTH             = 4;
    localparam int QPTR_W             = $clog2(QDEPTH);
    localparam int QCNT_W             = $clog2(QDEPTH + 1);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out;

    // One classified beat: the pair together with its carrier value.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] carrier;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_item;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // One Horner step: t = 1 - x2*t/div, floored at zero.
    function automatic longint unsigned horner_clip(input longint unsigned p);
        horner_clip = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
    endfunction

    // Sine of x (Q2.30 radians, first quadrant) in Q30, by a Taylor series.
    function automatic longint unsigned quarter_sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = horner_clip(((x2 * t) >> 30) / 64'd156);
        t  = horner_clip(((x2 * t) >> 30) / 64'd110);
        t  = horner_clip(((x2 * t) >> 30) / 64'd72);
        t  = horner_clip(((x2 * t) >> 30) / 64'd42);
        t  = horner_clip(((x2 * t) >> 30) / 64'd20);
        t  = horner_clip(((x2 * t) >> 30) / 64'd6);
        quarter_sine_q30 = (x * t) >> 30;
    endfunction

    // Q1.15 table entry k of a table with 2^abits entries; used at elaboration.
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k,
                                                              input int unsigned abits);
        int unsigned     qbits;
        int unsigned     quarter;
        int unsigned     quad;
        int unsigned     r;
        longint unsigned x;
        longint unsigned s;
        longint unsigned mag;
        qbits   = abits - 2;
        quarter = 32'd1 << qbits;
        quad    = (k >> qbits) & 32'd3;
        r       = k & (quarter - 32'd1);
        if (quad[0]) begin
            r = quarter - r;
        end
        x   = (64'(r) * HALF_PI_Q30) >> qbits;
        s   = quarter_sine_q30(x);
        mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        if (quad[1]) begin
            sine_entry = -SAMPLE_W'(mag);
        end else begin
            sine_entry = SAMPLE_W'(mag);
        end
    endfunction

endpackage

FILE: rtl/srm_front.sv
// Front end: accepts stereo pairs, runs the phase accumulator and looks up
// the carrier. Depends on srm_pkg for types and the sine table builder.
module srm_front #(
    parameter int SINE_ADDR_BITS = srm_pkg::SINE_ADDR_BITS_DEF,
    parameter int PHASE_BITS     = srm_pkg::PHASE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [srm_pkg::STEP_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  srm_pkg::t_in                i_in_data,
    input  logic                        i_q_full,
    output logic                        o_push,
    output srm_pkg::t_item              o_item
);

    localparam int ROM_DEPTH = 2 ** SINE_ADDR_BITS;

    logic signed [srm_pkg::SAMPLE_W-1:0] w_rom [ROM_DEPTH];

    for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
        localparam logic signed [srm_pkg::SAMPLE_W-1:0] ENTRY =
            srm_pkg::sine_entry(k, SINE_ADDR_BITS);
        assign w_rom[k] = ENTRY;
    end

    logic [srm_pkg::STEP_W-1:0]  r_phase_step;
    logic [PHASE_BITS-1:0]       r_phase_acc;
    logic [PHASE_BITS-1:0]       n_phase_acc;
    logic                        r_valid;
    logic                        n_valid;
    srm_pkg::t_item              r_item;
    logic [SINE_ADDR_BITS-1:0]   w_addr;
    logic                        w_advance;
    logic                        w_accept;

    // The stage moves on when it is empty or its beat goes into the queue.
    assign w_advance  = !r_valid || !i_q_full;
    assign w_accept   = i_in_valid && w_advance;
    assign o_in_stall = !w_advance;
    assign o_push     = r_valid && !i_q_full;
    assign o_item     = r_item;

    assign w_addr = r_phase_acc[PHASE_BITS-1 -: SINE_ADDR_BITS];

    always_comb begin
        n_phase_acc = r_phase_acc;
        n_valid     = r_valid;
        if (w_accept) begin
            n_phase_acc = r_phase_acc + r_phase_step[srm_pkg::STEP_W-1 -: PHASE_BITS];
            n_valid     = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_phase_acc  <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_step <= i_cfg_data;
            end
            r_phase_acc <= n_phase_acc;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.carrier      <= w_rom[w_addr];
            r_item.left_sample  <= i_in_data.left_sample;
            r_item.right_sample <= i_in_data.right_sample;
        end
    end

endmodule

FILE: rtl/srm_queue.sv
// Short FIFO between the front end and the multiply stage.
// Depends on srm_pkg for the item type, depth and status struct.
module srm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  srm_pkg::t_item     i_item,
    input  logic               i_pop,
    output srm_pkg::t_item     o_head,
    output srm_pkg::t_q_status o_status
);

    srm_pkg::t_item                r_mem [srm_pkg::QDEPTH];
    logic [srm_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [srm_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [srm_pkg::QCNT_W-1:0]    r_count;
    logic [srm_pkg::QCNT_W-1:0]    n_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == srm_pkg::QCNT_W'(srm_pkg::QDEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.count  = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: rtl/srm_back.sv
// Back end: multiplies both samples by the carrier and holds the result beat.
// Depends on srm_pkg for the item and output types.
module srm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srm_pkg::t_item     i_head,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srm_pkg::t_out      o_out_data
);

    localparam int PROD_W = 2 * srm_pkg::SAMPLE_W;

    logic signed [PROD_W-1:0]           w_prod_l;
    logic signed [PROD_W-1:0]           w_prod_r;
    logic signed [PROD_W-1:0]           w_q_l;
    logic signed [PROD_W-1:0]           w_q_r;
    logic                               r_valid;
    srm_pkg::t_out                      r_out;

    // Bias negative products so the shift truncates toward zero.
    localparam logic signed [PROD_W-1:0] BIAS = PROD_W'(32767);

    assign w_prod_l = i_head.left_sample * i_head.carrier;
    assign w_prod_r = i_head.right_sample * i_head.carrier;
    assign w_q_l    = (w_prod_l < 0) ? ((w_prod_l + BIAS) >>> 15) : (w_prod_l >>> 15);
    assign w_q_r    = (w_prod_r < 0) ? ((w_prod_r + BIAS) >>> 15) : (w_prod_r >>> 15);

    assign o_pop       = !i_q_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.left_out  <= w_q_l[srm_pkg::SAMPLE_W-1:0];
            r_out.right_out <= w_q_r[srm_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

FILE: rtl/stereo_ring_modulator.sv
// Channel   Direction  Handshake                Beat
// input     in         i_in_valid / o_in_stall  i_in_data   (t_in, one stereo pair)
// output    out        o_out_valid / i_out_stall o_out_data (t_out, one modulated pair)
// config    in         i_cfg_we                 i_cfg_data  (phase step)
//
// One pair is taken every cycle while o_in_stall is low; the multiply stage and
// its output register sustain one beat per cycle unless i_out_stall holds them,
// so with no stall the rate is one pair per clock. Each result passes the front
// register, the queue and the output register before it is valid.
// Synchronous active-low reset clears the phase, the step and the queue.
// The input stalls only when the front register holds a beat and the
// four-entry queue is full; the queue absorbs output stalls until then.
// Top level of the ring modulator; depends on srm_pkg, srm_front, srm_queue,
// srm_back and assert_macros.svh.
`include "assert_macros.svh"

module stereo_ring_modulator #(
    parameter int SINE_ADDR_BITS = srm_pkg::SINE_ADDR_BITS_DEF,
    parameter int PHASE_BITS     = srm_pkg::PHASE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [srm_pkg::STEP_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  srm_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output srm_pkg::t_out               o_out_data
);

    logic               w_push;
    logic               w_pop;
    srm_pkg::t_item     w_item;
    srm_pkg::t_item     w_head;
    srm_pkg::t_q_status w_q_status;

    srm_front #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .PHASE_BITS     (PHASE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_status.full),
        .o_push     (w_push),
        .o_item     (w_item)
    );

    srm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    srm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_empty   (w_q_status.empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Queue bookkeeping and front-end backpressure must agree.
    `SRM_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, w_push && w_q_status.full)
    `SRM_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, w_pop && w_q_status.empty)
    `SRM_ASSERT(a_count_bound, i_clk, i_rst_n, w_q_status.count <= srm_pkg::QDEPTH)
    `SRM_ASSERT(a_stall_only_full, i_clk, i_rst_n, o_in_stall |-> w_q_status.full)

endmodule
